[hdl/tcfa_pkg.sv]
// tcfa_pkg: shared constants, types and helpers for the two-class fifo arbiter
// no dependencies
`default_nettype none

package tcfa_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned TagW       = 32;
  localparam int unsigned AgeW       = 7;
  localparam int unsigned EntryW     = TagW + AgeW;

  localparam logic [AgeW-1:0] ThrReset = 7'd60;

  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_SERVE   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_ENQUEUED = 2'd0,
    STATUS_DROPPED  = 2'd1,
    STATUS_SERVED   = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOAD = 1'b1
  } state_e;

  typedef struct packed {
    logic accept;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop;
  } dp_status_t;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] res;
    if (ptr == PtrW'(QueueDepth - 1)) begin
      res = '0;
    end else begin
      res = ptr + PtrW'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/tcfa_ctrl.sv]
// tcfa_ctrl: handshake and sequencing state machine of the arbiter
// depends on tcfa_pkg
`default_nettype none

module tcfa_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire tcfa_pkg::dp_status_t   stat_i,
  output tcfa_pkg::ctrl_cmd_t         cmd_o
);
  import tcfa_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   taken;

  assign taken  = out_valid_q && m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && stat_i.pop) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cmd_o.accept  = 1'b0;
    cmd_o.load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = !out_valid_q || m_axis_tready;
        cmd_o.accept  = accept;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !taken;
    if ((cmd_o.accept && !stat_i.pop) || cmd_o.load) begin
      out_valid_d = 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && stat_i.pop |=> cmd_o.load)
    else $error("serve with pop not followed by load");
  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !out_valid_q)
    else $error("load while output register occupied");
  a_no_accept_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !s_axis_tready)
    else $error("input accepted during load");
`endif

endmodule

`default_nettype wire

[hdl/tcfa_dp.sv]
// tcfa_dp: fifo storage, pointers, turn flag, threshold and result register
// depends on tcfa_pkg
`default_nettype none

module tcfa_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tcfa_pkg::AgeW-1:0]   cfg_wdata_i,
  input  wire logic                        mode_i,
  input  wire logic [tcfa_pkg::TagW-1:0]   tag_i,
  input  wire logic [tcfa_pkg::AgeW-1:0]   age_i,
  input  wire tcfa_pkg::ctrl_cmd_t         cmd_i,
  output tcfa_pkg::dp_status_t             stat_o,
  output logic [1:0]                       status_o,
  output logic [tcfa_pkg::TagW-1:0]        served_tag_o,
  output logic [tcfa_pkg::AgeW-1:0]        served_age_o,
  output logic                             served_priority_o
);
  import tcfa_pkg::*;

  logic [EntryW-1:0] p_mem [QueueDepth];
  logic [EntryW-1:0] r_mem [QueueDepth];
  logic [EntryW-1:0] p_rd_q, r_rd_q;

  logic [PtrW-1:0] p_head_q, p_head_d, p_tail_q, p_tail_d;
  logic [PtrW-1:0] r_head_q, r_head_d, r_tail_q, r_tail_d;
  logic [CntW-1:0] p_cnt_q, p_cnt_d, r_cnt_q, r_cnt_d;
  logic            turn_q, turn_d;
  logic            sel_q, sel_d;
  logic [AgeW-1:0] thr_q;

  logic to_prio, p_full, r_full, p_empty, r_empty, full, sel_prio;
  logic p_we, r_we;
  logic [EntryW-1:0] rd_entry;

  assign p_full   = (p_cnt_q == CntW'(QueueDepth));
  assign r_full   = (r_cnt_q == CntW'(QueueDepth));
  assign p_empty  = (p_cnt_q == '0);
  assign r_empty  = (r_cnt_q == '0);
  assign to_prio  = (age_i >= thr_q);
  assign full     = to_prio ? p_full : r_full;
  assign sel_prio = (turn_q && !p_empty) || r_empty;

  assign stat_o.pop = (mode_i == MODE_SERVE) && !(p_empty && r_empty);

  assign p_we = cmd_i.accept && (mode_i == MODE_ENQUEUE) && to_prio && !p_full;
  assign r_we = cmd_i.accept && (mode_i == MODE_ENQUEUE) && !to_prio && !r_full;

  always_comb begin
    p_head_d = p_head_q;
    p_tail_d = p_tail_q;
    p_cnt_d  = p_cnt_q;
    r_head_d = r_head_q;
    r_tail_d = r_tail_q;
    r_cnt_d  = r_cnt_q;
    turn_d   = turn_q;
    sel_d    = sel_q;
    if (p_we) begin
      p_tail_d = next_ptr(p_tail_q);
      p_cnt_d  = p_cnt_q + CntW'(1);
    end
    if (r_we) begin
      r_tail_d = next_ptr(r_tail_q);
      r_cnt_d  = r_cnt_q + CntW'(1);
    end
    if (cmd_i.accept && stat_o.pop) begin
      sel_d  = sel_prio;
      turn_d = !sel_prio;
      if (sel_prio) begin
        p_head_d = next_ptr(p_head_q);
        p_cnt_d  = p_cnt_q - CntW'(1);
      end else begin
        r_head_d = next_ptr(r_head_q);
        r_cnt_d  = r_cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_head_q <= '0;
      p_tail_q <= '0;
      p_cnt_q  <= '0;
      r_head_q <= '0;
      r_tail_q <= '0;
      r_cnt_q  <= '0;
      turn_q   <= 1'b1;
      sel_q    <= 1'b0;
      thr_q    <= ThrReset;
    end else begin
      p_head_q <= p_head_d;
      p_tail_q <= p_tail_d;
      p_cnt_q  <= p_cnt_d;
      r_head_q <= r_head_d;
      r_tail_q <= r_tail_d;
      r_cnt_q  <= r_cnt_d;
      turn_q   <= turn_d;
      sel_q    <= sel_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // entry layout: tag in the upper bits, age in the lower bits
  always_ff @(posedge clk_i) begin
    if (p_we) begin
      p_mem[p_tail_q] <= {tag_i, age_i};
    end
    if (r_we) begin
      r_mem[r_tail_q] <= {tag_i, age_i};
    end
    if (cmd_i.accept) begin
      p_rd_q <= p_mem[p_head_q];
      r_rd_q <= r_mem[r_head_q];
    end
  end

  assign rd_entry = sel_q ? p_rd_q : r_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !stat_o.pop) begin
      if (mode_i == MODE_ENQUEUE) begin
        status_o <= full ? STATUS_DROPPED : STATUS_ENQUEUED;
      end else begin
        status_o <= STATUS_EMPTY;
      end
      served_tag_o      <= '0;
      served_age_o      <= '0;
      served_priority_o <= 1'b0;
    end else if (cmd_i.load) begin
      status_o          <= STATUS_SERVED;
      served_tag_o      <= rd_entry[EntryW-1:AgeW];
      served_age_o      <= rd_entry[AgeW-1:0];
      served_priority_o <= sel_q;
    end
  end

`ifndef NO_ASSERTIONS
  logic [CntW:0] cnt_sum;
  assign cnt_sum = {1'b0, p_cnt_q} + {1'b0, r_cnt_q};

  a_p_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_cnt_q <= CntW'(QueueDepth))
    else $error("priority count above depth");
  a_r_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_cnt_q <= CntW'(QueueDepth))
    else $error("regular count above depth");
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && stat_o.pop |=> cnt_sum == $past(cnt_sum) - (CntW+1)'(1))
    else $error("serve did not remove exactly one entry");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && stat_o.pop && sel_prio |-> !p_empty)
    else $error("pop from empty priority fifo");
`endif

endmodule

`default_nettype wire

[hdl/two_class_fifo_alternating_arbiter.sv]
// two_class_fifo_alternating_arbiter: enqueue result registered in the cycle after accept;
// a popping serve goes through load state and registered fifo read, holding input off in load.
// enqueue and empty-serve items: one per cycle while each result is taken.
// a waiting result holds the input off until it is taken; both can move in one cycle.
// reset clears pointers, counts and output valid, sets the turn flag and loads
// threshold 60; fifo storage is not cleared and no clearing pass is run.
`default_nettype none

module two_class_fifo_alternating_arbiter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,   // age_threshold
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // customer_tag[31:0], age[38:32], zero[39]
  input  wire logic        s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // served_tag[31:0], served_age[38:32], served_priority[39]
  output logic [1:0]       m_axis_tuser   // status
);
  import tcfa_pkg::*;

  ctrl_cmd_t       cmd;
  dp_status_t      stat;
  logic [TagW-1:0] served_tag;
  logic [AgeW-1:0] served_age;
  logic            served_priority;

  tcfa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  tcfa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mode_i            (s_axis_tuser),
    .tag_i             (s_axis_tdata[31:0]),
    .age_i             (s_axis_tdata[38:32]),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .status_o          (m_axis_tuser),
    .served_tag_o      (served_tag),
    .served_age_o      (served_age),
    .served_priority_o (served_priority)
  );

  assign m_axis_tdata = {served_priority, served_age, served_tag};

endmodule

`default_nettype wire
